// File: rtl/core/anac_pkg.sv
package anac_pkg;

  localparam int unsigned MaxParamBytesDefault = 64;
  localparam int unsigned MsgSizeBitsDefault   = 24;

  localparam logic [4:0] NalTypeMask = 5'h1F;
  localparam logic [7:0] ScZero      = 8'h00;
  localparam logic [7:0] ScOne       = 8'h01;

  localparam logic [4:0] NT_NON_IDR = 5'd1;
  localparam logic [4:0] NT_IDR     = 5'd5;
  localparam logic [4:0] NT_SPS     = 5'd7;
  localparam logic [4:0] NT_PPS     = 5'd8;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_SPS    = 2'd1;
  localparam logic [1:0] KIND_PPS    = 2'd2;
  localparam logic [1:0] KIND_MARKER = 2'd3;

  localparam int unsigned JobSlots = 7;

  typedef struct packed {
    logic       mpre;
    logic       sc;
    logic       body;
    logic [1:0] kind;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       changed;
    logic       mpost;
  } job_t;

  function automatic logic is_frame(input logic [4:0] t);
    return (t == NT_NON_IDR) || (t == NT_IDR);
  endfunction

  function automatic logic is_param(input logic [4:0] t);
    return (t == NT_SPS) || (t == NT_PPS);
  endfunction

endpackage

// File: rtl/core/avcc_to_annexb_nal_converter.sv
// Path: an accepted byte is registered in the parser, queued, then registered at the output.
// Throughput: one byte per cycle while the queue has room; the result unit sends one result
// per cycle unless the output stalls, so a frame's first body byte becomes a start code, the
// byte and any due marker; the two-entry queue between parser and result unit absorbs bursts.
// Reset is asynchronous and active low; the parameter stores hold no data after reset.
module avcc_to_annexb_nal_converter import anac_pkg::*; #(
  parameter int unsigned MaxParamBytes = MaxParamBytesDefault,
  parameter int unsigned MsgSizeBits   = MsgSizeBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   msg_last_i,
  input  logic [MsgSizeBits-1:0] msg_size_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             out_byte_o,
  output logic                   nal_first_o,
  output logic                   nal_last_o,
  output logic                   param_changed_o,
  output logic                   run_last_o
);

  logic push, full, pop, empty;
  job_t job, head;

  anac_front #(.MaxParamBytes(MaxParamBytes), .MsgSizeBits(MsgSizeBits)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .msg_last_i   (msg_last_i),
    .msg_size_i   (msg_size_i),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (job)
  );

  anac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  anac_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .nal_first_o     (nal_first_o),
    .nal_last_o      (nal_last_o),
    .param_changed_o (param_changed_o),
    .run_last_o      (run_last_o)
  );

endmodule

// File: rtl/core/anac_ram.sv
module anac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/anac_front.sv
module anac_front import anac_pkg::*; #(
  parameter int unsigned MaxParamBytes = MaxParamBytesDefault,
  parameter int unsigned MsgSizeBits   = MsgSizeBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   msg_last_i,
  input  logic [MsgSizeBits-1:0] msg_size_i,
  input  logic                   queue_full_i,
  output logic                   push_o,
  output job_t                   job_o
);

  localparam int unsigned AW = $clog2(MaxParamBytes);
  localparam int unsigned LW = $clog2(MaxParamBytes + 1);
  localparam int unsigned CW = 34;

  typedef struct packed {
    logic          body;
    logic          first;
    logic          lastb;
    logic          frame;
    logic          param;
    logic          sps;
    logic          fits;
    logic          idx_small;
    logic [AW-1:0] addr;
    logic [31:0]   nal;
    logic [7:0]    data;
    logic          last;
    logic          lastclr;
  } s1_t;

  logic [1:0]             phase_q, phase_d;
  logic [1:0]             lbc_q, lbc_d;
  logic [31:0]            nal_q, nal_d;
  logic [MsgSizeBits-1:0] off_q, off_d;
  logic [31:0]            rem_q, rem_d;
  logic [4:0]             type_q, type_d;

  logic        accept;
  logic        take;
  logic        s1_v_q;
  s1_t         s1_q, s1_d;
  logic [31:0] nal_sh;
  logic [31:0] idx;
  logic        sps_we, pps_we;
  logic [7:0]  sps_rd, pps_rd;

  logic [LW-1:0] sps_len_q, sps_len_d, pps_len_q, pps_len_d;
  logic          cmp_q, cmp_d, dirty_q, dirty_d, mdone_q, mdone_d;

  assign in_stall_o = s1_v_q && queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = s1_v_q && !queue_full_i;
  assign nal_sh     = {nal_q[23:0], in_byte_i};
  assign idx        = nal_q - rem_q;

  always_comb begin
    phase_d = phase_q;
    lbc_d   = lbc_q;
    nal_d   = nal_q;
    off_d   = off_q;
    rem_d   = rem_q;
    type_d  = type_q;
    s1_d    = '0;
    s1_d.data      = in_byte_i;
    s1_d.last      = msg_last_i;
    s1_d.nal       = nal_q;
    s1_d.addr      = idx[AW-1:0];
    s1_d.idx_small = idx < 32'(MaxParamBytes);
    s1_d.fits      = nal_q <= 32'(MaxParamBytes);
    s1_d.first     = idx == 32'd0;
    s1_d.lastb     = rem_q == 32'd1;
    unique case (phase_q)
      PH_LEN: begin
        if (lbc_q == 2'd0 &&
            (CW'(off_q) + CW'(4)) > CW'(msg_size_i)) begin
          phase_d = PH_STOP;
        end else begin
          nal_d = nal_sh;
          if (lbc_q == 2'd3) begin
            lbc_d = 2'd0;
            if (nal_sh == 32'd0 ||
                (CW'(off_q) + CW'(1) + CW'(nal_sh)) > CW'(msg_size_i)) begin
              phase_d = PH_STOP;
            end else begin
              phase_d = PH_BODY;
              rem_d   = nal_sh;
            end
          end else begin
            lbc_d = lbc_q + 2'd1;
          end
        end
      end
      PH_BODY: begin
        s1_d.body = 1'b1;
        if (s1_d.first) begin
          type_d = in_byte_i[4:0] & NalTypeMask;
        end
        rem_d = rem_q - 32'd1;
        if (rem_d == 32'd0) begin
          phase_d = PH_LEN;
        end
      end
      default: begin
      end
    endcase
    s1_d.frame = is_frame(type_d);
    s1_d.param = is_param(type_d);
    s1_d.sps   = type_d == NT_SPS;
    if (off_q != '1) begin
      off_d = off_q + MsgSizeBits'(1);
    end
    if (msg_last_i) begin
      s1_d.lastclr = (phase_d == PH_BODY) && is_param(type_d) &&
                     (nal_d <= 32'(MaxParamBytes));
      phase_d = PH_LEN;
      lbc_d   = 2'd0;
      nal_d   = 32'd0;
      rem_d   = 32'd0;
      off_d   = '0;
      type_d  = 5'd0;
    end
  end

  assign sps_we = accept && s1_d.body && s1_d.param && s1_d.fits && s1_d.idx_small &&
                  s1_d.sps;
  assign pps_we = accept && s1_d.body && s1_d.param && s1_d.fits && s1_d.idx_small &&
                  !s1_d.sps;

  anac_ram #(.Width(8), .Depth(MaxParamBytes)) u_sps_ram (
    .clk_i   (clk_i),
    .we_i    (sps_we),
    .waddr_i (s1_d.addr),
    .wdata_i (in_byte_i),
    .re_i    (accept),
    .raddr_i (s1_d.addr),
    .rdata_o (sps_rd)
  );

  anac_ram #(.Width(8), .Depth(MaxParamBytes)) u_pps_ram (
    .clk_i   (clk_i),
    .we_i    (pps_we),
    .waddr_i (s1_d.addr),
    .wdata_i (in_byte_i),
    .re_i    (accept),
    .raddr_i (s1_d.addr),
    .rdata_o (pps_rd)
  );

  always_comb begin
    logic [LW-1:0] sl;
    logic [7:0]    rd;
    logic          held;
    sl        = s1_q.sps ? sps_len_q : pps_len_q;
    rd        = s1_q.sps ? sps_rd : pps_rd;
    held      = (sps_len_q != '0) && (pps_len_q != '0);
    sps_len_d = sps_len_q;
    pps_len_d = pps_len_q;
    cmp_d     = cmp_q;
    dirty_d   = dirty_q;
    mdone_d   = mdone_q;
    job_o     = '0;
    job_o.data = s1_q.data;
    if (s1_q.body && s1_q.first && s1_q.frame) begin
      job_o.sc = 1'b1;
      if (!mdone_q) begin
        mdone_d = 1'b1;
        if (dirty_q && held) begin
          job_o.mpre = 1'b1;
          dirty_d    = 1'b0;
        end
      end
    end
    if (s1_q.body && s1_q.frame) begin
      job_o.body = 1'b1;
      job_o.kind = KIND_FRAME;
      job_o.last = s1_q.lastb;
    end else if (s1_q.body && s1_q.param) begin
      if (s1_q.first) begin
        cmp_d = 32'(sl) != s1_q.nal;
      end
      if (s1_q.idx_small && (LW'(s1_q.addr) < sl) && (rd != s1_q.data)) begin
        cmp_d = 1'b1;
      end
      job_o.body    = 1'b1;
      job_o.kind    = s1_q.sps ? KIND_SPS : KIND_PPS;
      job_o.first   = s1_q.first;
      job_o.last    = s1_q.lastb;
      job_o.changed = s1_q.lastb && s1_q.fits && cmp_d;
      if (job_o.changed) begin
        dirty_d = 1'b1;
        if (s1_q.sps) begin
          sps_len_d = s1_q.nal[LW-1:0];
        end else begin
          pps_len_d = s1_q.nal[LW-1:0];
        end
      end
    end
    if (s1_q.last) begin
      if (s1_q.lastclr) begin
        if (s1_q.sps) begin
          sps_len_d = '0;
        end else begin
          pps_len_d = '0;
        end
      end
      if (dirty_d && (sps_len_d != '0) && (pps_len_d != '0)) begin
        job_o.mpost = 1'b1;
        dirty_d     = 1'b0;
      end
      cmp_d   = 1'b0;
      mdone_d = 1'b0;
    end
  end

  assign push_o = take && (job_o.mpre || job_o.sc || job_o.body || job_o.mpost);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN;
      lbc_q     <= 2'd0;
      nal_q     <= 32'd0;
      off_q     <= '0;
      rem_q     <= 32'd0;
      type_q    <= 5'd0;
      s1_v_q    <= 1'b0;
      sps_len_q <= '0;
      pps_len_q <= '0;
      cmp_q     <= 1'b0;
      dirty_q   <= 1'b0;
      mdone_q   <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        lbc_q   <= lbc_d;
        nal_q   <= nal_d;
        off_q   <= off_d;
        rem_q   <= rem_d;
        type_q  <= type_d;
      end
      s1_v_q <= accept || (s1_v_q && !take);
      if (take) begin
        sps_len_q <= sps_len_d;
        pps_len_q <= pps_len_d;
        cmp_q     <= cmp_d;
        dirty_q   <= dirty_d;
        mdone_q   <= mdone_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

endmodule

// File: rtl/core/anac_queue.sv
module anac_queue import anac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/core/anac_back.sv
module anac_back import anac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       nal_first_o,
  output logic       nal_last_o,
  output logic       param_changed_o,
  output logic       run_last_o
);

  logic [JobSlots-1:0] cur_mask_q, cur_mask_d, src_mask, onehot, rest, head_mask;
  job_t                cur_job_q, src_job;
  logic                free, emit;
  logic                out_v_q;
  logic [1:0]          kind_d;
  logic [7:0]          byte_d;
  logic                first_d, last_d, changed_d;

  assign head_mask = {head_i.mpost, head_i.body, {4{head_i.sc}}, head_i.mpre};
  assign src_mask  = (cur_mask_q != '0) ? cur_mask_q :
                     (empty_i ? '0 : head_mask);
  assign src_job   = (cur_mask_q != '0) ? cur_job_q : head_i;
  assign onehot    = src_mask & (~src_mask + JobSlots'(1));
  assign rest      = src_mask & ~onehot;
  assign free      = !out_v_q || !out_stall_i;
  assign emit      = free && (src_mask != '0);
  assign pop_o     = emit && (cur_mask_q == '0);
  assign cur_mask_d = emit ? rest : cur_mask_q;

  always_comb begin
    kind_d    = KIND_MARKER;
    byte_d    = 8'h00;
    first_d   = 1'b0;
    last_d    = 1'b0;
    changed_d = 1'b0;
    if (onehot[5]) begin
      kind_d    = src_job.kind;
      byte_d    = src_job.data;
      first_d   = src_job.first;
      last_d    = src_job.last;
      changed_d = src_job.changed;
    end else if (onehot[4:1] != 4'd0) begin
      kind_d  = KIND_FRAME;
      byte_d  = onehot[4] ? ScOne : ScZero;
      first_d = onehot[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mask_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      cur_mask_q <= cur_mask_d;
      if (free) begin
        out_v_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_job_q <= head_i;
    end
    if (emit) begin
      kind_o          <= kind_d;
      out_byte_o      <= byte_d;
      nal_first_o     <= first_d;
      nal_last_o      <= last_d;
      param_changed_o <= changed_d;
      run_last_o      <= rest == '0;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// File: tb/sv/tb_avcc_to_annexb_nal_converter.sv
`timescale 1ns / 100ps

module tb_avcc_to_annexb_nal_converter;
  import anac_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [23:0] size;
  } in_txn_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       changed;
    logic       run_last;
  } out_txn_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        msg_last_i;
  logic [23:0] msg_size_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic        nal_first_o;
  logic        nal_last_o;
  logic        param_changed_o;
  logic        run_last_o;

  avcc_to_annexb_nal_converter u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_byte_i,
    .msg_last_i,
    .msg_size_i,
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .out_byte_o,
    .nal_first_o,
    .nal_last_o,
    .param_changed_o,
    .run_last_o
  );

  in_txn_t  byte_q[$];
  out_txn_t annexb_q[$];
  logic [7:0] msg_buf[$];
  logic [7:0] last_sps[$];
  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int markers_seen = 0;
  int param_bytes_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic [15:0] stall_pat = '0;
  int stall_pos = 0;

  // Shadow of the converter state.
  logic [1:0]  ph;
  int          len_cnt;
  logic [31:0] nal_len;
  logic [23:0] msg_off;
  logic [31:0] body_left;
  logic [4:0]  cur_type;
  logic [7:0]  sps_mem[64];
  logic [7:0]  pps_mem[64];
  int          sps_len;
  int          pps_len;
  logic        differs;
  logic        dirty;
  logic        marker_sent;
  int          n_res;

  task automatic push_result(input logic [1:0] k, input logic [7:0] d, input logic f,
                             input logic l, input logic c);
    out_txn_t r;
    r.kind = k;
    r.data = d;
    r.first = f;
    r.last = l;
    r.changed = c;
    r.run_last = 1'b0;
    annexb_q.push_back(r);
    n_res++;
  endtask

  task automatic maybe_marker();
    if (dirty && sps_len != 0 && pps_len != 0) begin
      push_result(KIND_MARKER, 8'h00, 1'b0, 1'b0, 1'b0);
      dirty = 1'b0;
    end
  endtask

  task automatic predict_annexb(input logic [7:0] b, input logic lst, input logic [23:0] sz);
    int idx;
    logic lastb;
    logic fits;
    logic is_sps;
    int plen;
    n_res = 0;
    if (ph == PH_LEN) begin
      if (len_cnt == 0 && longint'(msg_off) + 4 > longint'(sz)) begin
        ph = PH_STOP;
      end else begin
        nal_len = {nal_len[23:0], b};
        if (len_cnt == 3) begin
          len_cnt = 0;
          if (nal_len == 0 || longint'(msg_off) + 1 + longint'(nal_len) > longint'(sz)) begin
            ph = PH_STOP;
          end else begin
            ph = PH_BODY;
            body_left = nal_len;
          end
        end else begin
          len_cnt++;
        end
      end
    end else if (ph == PH_BODY) begin
      idx = int'(nal_len - body_left);
      lastb = (body_left == 1);
      if (idx == 0) begin
        cur_type = b[4:0] & NalTypeMask;
        if (cur_type == NT_IDR || cur_type == NT_NON_IDR) begin
          if (!marker_sent) begin
            marker_sent = 1'b1;
            maybe_marker();
          end
          push_result(KIND_FRAME, ScZero, 1'b1, 1'b0, 1'b0);
          push_result(KIND_FRAME, ScZero, 1'b0, 1'b0, 1'b0);
          push_result(KIND_FRAME, ScZero, 1'b0, 1'b0, 1'b0);
          push_result(KIND_FRAME, ScOne, 1'b0, 1'b0, 1'b0);
        end else if (cur_type == NT_SPS || cur_type == NT_PPS) begin
          plen = (cur_type == NT_SPS) ? sps_len : pps_len;
          differs = (longint'(plen) != longint'(nal_len));
        end
      end
      if (cur_type == NT_IDR || cur_type == NT_NON_IDR) begin
        push_result(KIND_FRAME, b, 1'b0, lastb, 1'b0);
      end else if (cur_type == NT_SPS || cur_type == NT_PPS) begin
        is_sps = (cur_type == NT_SPS);
        fits = (nal_len <= 64);
        plen = is_sps ? sps_len : pps_len;
        if (idx < plen && idx < 64) begin
          if ((is_sps ? sps_mem[idx] : pps_mem[idx]) != b) differs = 1'b1;
        end
        if (fits && idx < 64) begin
          if (is_sps) sps_mem[idx] = b;
          else pps_mem[idx] = b;
        end
        push_result(is_sps ? KIND_SPS : KIND_PPS, b, idx == 0, lastb,
                    lastb && fits && differs);
        if (lastb && fits && differs) begin
          dirty = 1'b1;
          if (is_sps) sps_len = int'(nal_len);
          else pps_len = int'(nal_len);
        end
      end
      body_left--;
      if (body_left == 0) ph = PH_LEN;
    end
    if (msg_off != 24'hFFFFFF) msg_off++;
    if (lst) begin
      if (ph == PH_BODY && nal_len <= 64) begin
        if (cur_type == NT_SPS) sps_len = 0;
        else if (cur_type == NT_PPS) pps_len = 0;
      end
      maybe_marker();
      ph = PH_LEN;
      len_cnt = 0;
      nal_len = '0;
      body_left = '0;
      msg_off = '0;
      cur_type = '0;
      differs = 1'b0;
      marker_sent = 1'b0;
    end
    if (n_res > 0) annexb_q[annexb_q.size() - 1].run_last = 1'b1;
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic add_nal(input logic [4:0] t, input int len, input logic [31:0] len_field);
    logic [7:0] v;
    bit reuse;
    reuse = (t == NT_SPS) && (last_sps.size() == len) && ($urandom_range(0, 1) == 1);
    for (int i = 3; i >= 0; i--) msg_buf.push_back(len_field[8*i +: 8]);
    if (!reuse && t == NT_SPS) last_sps.delete();
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom_range(0, 255));
      if (i == 0) v[4:0] = t;
      if (reuse) v = last_sps[i];
      else if (t == NT_SPS) last_sps.push_back(v);
      msg_buf.push_back(v);
    end
  endtask

  task automatic send_msg(input logic [23:0] sz);
    in_txn_t it;
    for (int i = 0; i < msg_buf.size(); i++) begin
      it.data = msg_buf[i];
      it.last = (i == msg_buf.size() - 1);
      it.size = sz;
      byte_q.push_back(it);
    end
    bytes_sent += msg_buf.size();
    msg_buf.delete();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_avcc_to_annexb_nal_converter: FAIL");
      $finish;
    end
  end

  // Sender: accept, predict, then present the next transaction in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i <= '0;
      msg_last_i <= 1'b0;
      msg_size_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_annexb(in_byte_i, msg_last_i, msg_size_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_byte_i <= byte_q[0].data;
          msg_last_i <= byte_q[0].last;
          msg_size_i <= byte_q[0].size;
          void'(byte_q.pop_front());
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (cycles % 64 == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
      end
      stall_pos = (stall_pos + 1) % 16;
      out_stall_i <= stall_pat[stall_pos];
    end
  end

  always @(posedge clk_i) begin
    out_txn_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (kind_o == KIND_MARKER) markers_seen++;
      if (kind_o == KIND_SPS || kind_o == KIND_PPS) param_bytes_seen++;
      if (annexb_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = annexb_q.pop_front();
        if (kind_o !== e.kind) report_mismatch($sformatf("kind %0d exp %0d", kind_o, e.kind));
        if (out_byte_o !== e.data)
          report_mismatch($sformatf("byte %h exp %h", out_byte_o, e.data));
        if (nal_first_o !== e.first) report_mismatch("nal_first");
        if (nal_last_o !== e.last) report_mismatch("nal_last");
        if (param_changed_o !== e.changed) report_mismatch("param_changed");
        if (run_last_o !== e.run_last) report_mismatch("run_last");
      end
    end
  end

  initial begin
    int mode;
    int nn;
    int len;
    int t;
    int sz;
    logic [31:0] lf;
    ph = PH_LEN;
    len_cnt = 0;
    nal_len = '0;
    msg_off = '0;
    body_left = '0;
    cur_type = '0;
    sps_len = 0;
    pps_len = 0;
    differs = 1'b0;
    dirty = 1'b0;
    marker_sent = 1'b0;
    rst_ni = 1'b0;

    // Parameter sets, a frame with extreme bytes, then a zero length.
    add_nal(NT_SPS, 1, 32'd1);
    add_nal(NT_PPS, 1, 32'd1);
    msg_buf.push_back(8'h00);
    msg_buf.push_back(8'h00);
    msg_buf.push_back(8'h00);
    msg_buf.push_back(8'h02);
    msg_buf.push_back(8'hE5);
    msg_buf.push_back(8'hFF);
    add_nal(NT_NON_IDR, 0, 32'd0);
    send_msg(24'd20);
    // Largest size with a cut-short frame and then a whole one, then a short remainder at size zero.
    add_nal(NT_IDR, 2, 32'hFFFFFFFF);
    send_msg(24'hFFFFFF);
    add_nal(NT_IDR, 2, 32'h00000002);
    send_msg(24'hFFFFFF);
    msg_buf.push_back(8'hFF);
    send_msg(24'd0);

    while (bytes_sent < 85) begin
      nn = $urandom_range(1, 3);
      for (int i = 0; i < nn; i++) begin
        case ($urandom_range(0, 5))
          0: t = NT_SPS;
          1: t = NT_PPS;
          2: t = NT_IDR;
          3: t = NT_NON_IDR;
          4: t = $urandom_range(0, 31);
          default: t = ($urandom_range(0, 1) == 1) ? NT_SPS : NT_PPS;
        endcase
        len = ($urandom_range(0, 3) == 0 && bytes_sent + msg_buf.size() < 40) ?
              $urandom_range(64, 66) : $urandom_range(1, 6);
        lf = 32'(len);
        if ($urandom_range(0, 19) == 0) lf = ($urandom_range(0, 1) == 1) ? 32'h0 : $urandom;
        add_nal(5'(t), len, lf);
      end
      sz = msg_buf.size();
      mode = $urandom_range(0, 9);
      if (mode == 7) sz = sz + $urandom_range(1, 3);
      else if (mode == 8 && sz > 2) sz = sz - $urandom_range(1, 2);
      else if (mode == 9) repeat ($urandom_range(1, 4)) void'(msg_buf.pop_back());
      if (msg_buf.size() == 0) msg_buf.push_back(8'($urandom));
      send_msg(24'(sz));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (byte_q.size() == 0 && !in_valid_i);
    wait (annexb_q.size() == 0);
    repeat (30) @(posedge clk_i);
    $display("Sent %0d payload bytes; checked %0d results (%0d markers, %0d parameter bytes).",
             bytes_sent, results_seen, markers_seen, param_bytes_seen);
    if (errors == 0) begin
      $display("tb_avcc_to_annexb_nal_converter: PASS");
    end else begin
      $display("tb_avcc_to_annexb_nal_converter: FAIL");
    end
    $finish;
  end

endmodule
